// File: rtl/core/mhgo_pkg.sv
package mhgo_pkg;

    localparam int VALUE_W  = 32;
    localparam int KEY_W    = 49;
    localparam int OFFSET_W = 48;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 56;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic load;
        logic add_off;
        logic set_empty;
        logic set_full;
        logic ins_start;
        logic pop_read;
        logic pop_take;
        logic emit;
        logic up_read;
        logic up_move;
        logic dn_read;
        logic dn_move;
        logic wr_key;
    } t_cmd;

    typedef struct packed {
        logic op_insert;
        logic op_add;
        logic count_zero;
        logic count_full;
        logic out_free;
        logic res_sift;
        logic pos_zero;
        logic left_out;
        logic up_swap;
        logic dn_swap;
    } t_status;

endpackage

// File: rtl/core/mhgo_ctrl.sv
module mhgo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mhgo_pkg::t_status i_status,
    output logic              o_ready,
    output mhgo_pkg::t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_EXEC     = 8'b0000_0010,
        S_POP_TAKE = 8'b0000_0100,
        S_EMIT     = 8'b0000_1000,
        S_UP_READ  = 8'b0001_0000,
        S_UP_CMP   = 8'b0010_0000,
        S_DN_READ  = 8'b0100_0000,
        S_DN_CMP   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.op_add) begin
                    o_cmd.add_off = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_status.op_insert) begin
                    if (i_status.count_full) begin
                        o_cmd.set_full = 1'b1;
                        n_state        = S_EMIT;
                    end else begin
                        o_cmd.ins_start = 1'b1;
                        n_state         = S_UP_READ;
                    end
                end else if (i_status.count_zero) begin
                    o_cmd.set_empty = 1'b1;
                    n_state         = S_EMIT;
                end else begin
                    o_cmd.pop_read = 1'b1;
                    n_state        = S_POP_TAKE;
                end
            end
            S_POP_TAKE: begin
                o_cmd.pop_take = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.res_sift ? S_DN_READ : S_IDLE;
                end
            end
            S_UP_READ: begin
                if (i_status.pos_zero) begin
                    o_cmd.wr_key = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.up_read = 1'b1;
                    n_state       = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_status.up_swap) begin
                    o_cmd.up_move = 1'b1;
                    n_state       = S_UP_READ;
                end else begin
                    o_cmd.wr_key = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DN_READ: begin
                if (i_status.left_out) begin
                    o_cmd.wr_key = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.dn_read = 1'b1;
                    n_state       = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_status.dn_swap) begin
                    o_cmd.dn_move = 1'b1;
                    n_state       = S_DN_READ;
                end else begin
                    o_cmd.wr_key = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/mhgo_dp.sv
module mhgo_dp #(
    parameter int HEAP_CAPACITY = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mhgo_pkg::t_cmd                        i_cmd,
    input  logic [mhgo_pkg::OP_W-1:0]             i_op,
    input  logic [mhgo_pkg::VALUE_W-1:0]          i_value,
    input  logic                                  i_out_ready,
    output mhgo_pkg::t_status                     o_status,
    output logic                                  o_out_valid,
    output logic [mhgo_pkg::KEY_W-1:0]            o_out_value,
    output logic [mhgo_pkg::STATUS_W-1:0]         o_out_status
);

    localparam int AW = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
    localparam int CW = $clog2(HEAP_CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam int KW = mhgo_pkg::KEY_W;
    localparam int OW = mhgo_pkg::OFFSET_W;
    localparam int VW = mhgo_pkg::VALUE_W;

    logic signed [KW-1:0] r_mem [HEAP_CAPACITY];

    logic [mhgo_pkg::OP_W-1:0]     r_op;
    logic [VW-1:0]                 r_value;
    logic [CW-1:0]                 r_count;
    logic [OW-1:0]                 r_offset;
    logic signed [KW-1:0]          r_key;
    logic [AW-1:0]                 r_pos;
    logic signed [KW-1:0]          r_rd_a;
    logic signed [KW-1:0]          r_rd_b;
    logic [KW-1:0]                 r_res_value;
    logic [mhgo_pkg::STATUS_W-1:0] r_res_status;
    logic                          r_out_valid;
    logic [KW-1:0]                 r_out_value;
    logic [mhgo_pkg::STATUS_W-1:0] r_out_status;

    logic [IW-1:0]        left_idx;
    logic [IW-1:0]        right_idx;
    logic [IW-1:0]        count_ext;
    logic [AW-1:0]        pos_m1;
    logic [AW-1:0]        parent_idx;
    logic                 right_in;
    logic                 take_right;
    logic signed [KW-1:0] best_key;
    logic [AW-1:0]        best_idx;
    logic [AW-1:0]        addr_a;
    logic [AW-1:0]        addr_b;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [KW-1:0] wr_data;
    logic [KW-1:0]        ins_key;
    logic [KW-1:0]        pop_sum;
    logic [OW:0]          off_sum;
    logic                 out_free;

    assign count_ext  = {{(IW-CW){1'b0}}, r_count};
    assign left_idx   = {1'b0, r_pos, 1'b1};
    assign right_idx  = left_idx + IW'(1);
    assign pos_m1     = r_pos - AW'(1);
    assign parent_idx = pos_m1 >> 1;
    assign right_in   = right_idx < count_ext;
    assign take_right = right_in && (r_rd_b < r_rd_a);
    assign best_key   = take_right ? r_rd_b : r_rd_a;
    assign best_idx   = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

    assign ins_key = {{(KW-VW){1'b0}}, r_value} - {1'b0, r_offset};
    assign pop_sum = r_rd_a + {1'b0, r_offset};
    assign off_sum = {1'b0, r_offset} + {{(OW+1-VW){1'b0}}, r_value};
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        addr_a = '0;
        addr_b = '0;
        if (i_cmd.pop_read) begin
            addr_b = AW'(r_count - CW'(1));
        end else if (i_cmd.up_read) begin
            addr_a = parent_idx;
        end else if (i_cmd.dn_read) begin
            addr_a = left_idx[AW-1:0];
            addr_b = right_idx[AW-1:0];
        end
    end

    always_comb begin
        wr_en   = i_cmd.wr_key | i_cmd.up_move | i_cmd.dn_move;
        wr_addr = r_pos;
        wr_data = r_key;
        if (i_cmd.up_move) begin
            wr_data = r_rd_a;
        end else if (i_cmd.dn_move) begin
            wr_data = best_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.add_off) begin
                r_offset <= off_sum[OW] ? {OW{1'b1}} : off_sum[OW-1:0];
            end
            if (i_cmd.ins_start) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_take) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
        if (i_cmd.ins_start) begin
            r_key <= ins_key;
            r_pos <= r_count[AW-1:0];
        end else if (i_cmd.pop_take) begin
            r_key <= r_rd_b;
            r_pos <= '0;
        end else if (i_cmd.up_move) begin
            r_pos <= parent_idx;
        end else if (i_cmd.dn_move) begin
            r_pos <= best_idx;
        end
        if (i_cmd.pop_take) begin
            r_res_value  <= pop_sum;
            r_res_status <= mhgo_pkg::ST_OK;
        end else if (i_cmd.set_empty) begin
            r_res_value  <= '0;
            r_res_status <= mhgo_pkg::ST_EMPTY;
        end else if (i_cmd.set_full) begin
            r_res_value  <= '0;
            r_res_status <= mhgo_pkg::ST_FULL;
        end
        if (i_cmd.emit) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    always_comb begin
        o_status.op_insert  = (r_op == mhgo_pkg::OP_INSERT);
        o_status.op_add     = (r_op == mhgo_pkg::OP_ADD);
        o_status.count_zero = (r_count == '0);
        o_status.count_full = (r_count >= CW'(HEAP_CAPACITY));
        o_status.out_free   = out_free;
        o_status.res_sift   = (r_res_status == mhgo_pkg::ST_OK) && (r_count != '0);
        o_status.pos_zero   = (r_pos == '0);
        o_status.left_out   = (left_idx >= count_ext);
        o_status.up_swap    = (r_rd_a > r_key);
        o_status.dn_swap    = (best_key < r_key);
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_status = r_out_status;

endmodule

// File: rtl/core/min_heap_with_global_offset.sv
// channel  direction  tdata                        tuser
// s_axis   in         [31:0] operand_value         [1:0] opcode
// m_axis   out        [48:0] popped_value, zeros   [1:0] status
//
// add only updates the offset; a dropped insert or an empty pop only emits its status;
// insert sifts up and pop sifts down, one level per read and compare, and a pop that
// empties the heap skips the sift; a result waits until the output register is free
// the sift loop over the single key memory (two reads, one write) sets the rate
// synchronous active-low reset clears the entry count, offset and output valid
// a stalled result sits in the output register while the next item is taken
module min_heap_with_global_offset #(
    parameter int HEAP_CAPACITY = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [mhgo_pkg::TDATA_IN_W-1:0]       i_s_axis_tdata,  // operand_value
    input  logic [mhgo_pkg::OP_W-1:0]             i_s_axis_tuser,  // opcode
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [mhgo_pkg::TDATA_OUT_W-1:0]      o_m_axis_tdata,  // popped_value, zero pad
    output logic [mhgo_pkg::STATUS_W-1:0]         o_m_axis_tuser   // status
);

    mhgo_pkg::t_cmd                cmd;
    mhgo_pkg::t_status             st;
    logic [mhgo_pkg::KEY_W-1:0]    out_value;

    mhgo_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_status (st),
        .o_ready  (o_s_axis_tready),
        .o_cmd    (cmd)
    );

    mhgo_dp #(
        .HEAP_CAPACITY (HEAP_CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_s_axis_tuser),
        .i_value      (i_s_axis_tdata),
        .i_out_ready  (i_m_axis_tready),
        .o_status     (st),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_value  (out_value),
        .o_out_status (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {{(mhgo_pkg::TDATA_OUT_W - mhgo_pkg::KEY_W){1'b0}}, out_value};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted on consecutive cycles");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(cmd.emit))
        else $error("result raised without emit command");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.wr_key, cmd.up_move, cmd.dn_move}))
        else $error("more than one key memory write source");

    a_no_accept_while_sifting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.dn_read || cmd.up_read |-> !o_s_axis_tready)
        else $error("input ready during sift");

endmodule
